// ===== hdl/tilt_and_edge_drive_supervisor_top_macros.svh =====
// Assertion helpers for the drive supervisor. Both sample on clk and are
// switched off while rst is high.
`ifndef TILT_AND_EDGE_DRIVE_SUPERVISOR_TOP_MACROS_SVH
`define TILT_AND_EDGE_DRIVE_SUPERVISOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAEDS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("taeds assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TAEDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("taeds assertion failed");

`endif

// ===== hdl/taeds_pkg.sv =====
package taeds_pkg;

  typedef enum logic [1:0] {
    MOVE_NONE    = 2'd0,
    MOVE_FORWARD = 2'd1,
    MOVE_STOP    = 2'd2,
    MOVE_TURN    = 2'd3
  } move_t;

  typedef enum logic [1:0] {
    STAB_NORMAL  = 2'd0,
    STAB_WARNING = 2'd1,
    STAB_DANGER  = 2'd2,
    STAB_UNUSED  = 2'd3
  } stab_t;

  typedef enum logic [1:0] {
    BUZZ_SILENT  = 2'd0,
    BUZZ_WARNING = 2'd1,
    BUZZ_DANGER  = 2'd2
  } buzz_t;

  typedef enum logic [2:0] {
    CFG_USER_SPEED      = 3'd0,
    CFG_TILT_THRESHOLD  = 3'd1,
    CFG_TILT_GAIN       = 3'd2,
    CFG_NO_OBJECT_CM    = 3'd3,
    CFG_EDGE_CONFIRM_MS = 3'd4,
    CFG_TURN_TIME_MS    = 3'd5
  } cfg_idx_t;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [6:0]  SpeedMin      = 7'd10;
  localparam logic [6:0]  SpeedMax      = 7'd100;
  localparam logic [15:0] MissStep      = 16'd10;

  typedef struct packed {
    logic        [9:0]  left_dist;
    logic        [9:0]  right_dist;
    logic signed [11:0] roll_tenths;
    logic signed [11:0] pitch_tenths;
    logic        [1:0]  stability;
    logic               tilt_online;
    logic               bin_full;
    logic        [7:0]  elapsed_ms;
  } tick_t;

  typedef struct packed {
    logic [1:0] move_cmd;
    logic       brake;
    logic       speed_valid;
    logic [6:0] drive_speed;
    logic [1:0] alarm_level;
    logic       turning;
  } result_t;

endpackage

// ===== hdl/taeds_if.sv =====
// Request channel: one control tick per handshake.
interface taeds_tick_if;
  logic             valid;
  logic             ready;
  taeds_pkg::tick_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel: one supervisor result per handshake.
interface taeds_result_if;
  logic               valid;
  logic               ready;
  taeds_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tilt_and_edge_drive_supervisor_top.sv =====
// Path: an accepted request is held in the input register, then moves into the result register that drives res.
// Throughput: one request per cycle; the input register and the result register
// each advance whenever the stage behind them is empty or being drained.
// Reset: rst is synchronous and active high; it empties both stages, clears the
// turn timer, the no-echo counters and the last move, and loads register defaults.
`include "tilt_and_edge_drive_supervisor_top_macros.svh"

module tilt_and_edge_drive_supervisor_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [taeds_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [taeds_pkg::CfgDataWidth-1:0]     cfg_data,
  taeds_tick_if.sink                             req,
  taeds_result_if.source                         res
);

  // Configuration registers, to be written only while the block is idle; the block does not enforce this.
  logic [6:0]  user_speed;
  logic [9:0]  tilt_threshold;
  logic [5:0]  tilt_gain;
  logic [9:0]  no_object_cm;
  logic [15:0] edge_confirm_ms;
  logic [15:0] turn_time_ms;

  // Supervisor state. It is read and written only by the request that moves
  // from the input register into the result register, so requests update it
  // strictly in order.
  logic             turn_active;
  logic [15:0]      turn_elapsed;
  logic [15:0]      left_miss_ms;
  logic [15:0]      right_miss_ms;
  taeds_pkg::move_t last_move;

  logic             turn_active_next;
  logic [15:0]      turn_elapsed_next;
  logic [15:0]      left_miss_ms_next;
  logic [15:0]      right_miss_ms_next;
  taeds_pkg::move_t last_move_next;

  // Input register and result register with their valid flags.
  logic               in_valid;
  taeds_pkg::tick_t   in_tick;
  logic               out_valid;
  taeds_pkg::result_t out_result;
  taeds_pkg::result_t result_next;

  logic advance;

  // The input stage moves on whenever the result register is empty or its
  // request is taken in the same cycle, so a waiting result holds off a new
  // request only once the input register is full as well.
  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;
  assign res.valid = out_valid;
  assign res.data  = out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_speed      <= 7'd30;
      tilt_threshold  <= 10'd150;
      tilt_gain       <= 6'd10;
      no_object_cm    <= 10'd100;
      edge_confirm_ms <= 16'd200;
      turn_time_ms    <= 16'd800;
    end else if (cfg_we) begin
      case (cfg_index)
        taeds_pkg::CFG_USER_SPEED:      user_speed      <= cfg_data[6:0];
        taeds_pkg::CFG_TILT_THRESHOLD:  tilt_threshold  <= cfg_data[9:0];
        taeds_pkg::CFG_TILT_GAIN:       tilt_gain       <= cfg_data[5:0];
        taeds_pkg::CFG_NO_OBJECT_CM:    no_object_cm    <= cfg_data[9:0];
        taeds_pkg::CFG_EDGE_CONFIRM_MS: edge_confirm_ms <= cfg_data;
        taeds_pkg::CFG_TURN_TIME_MS:    turn_time_ms    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Saturates a signed speed sum into the legal drive range.
  function automatic logic [6:0] clamp_speed(input logic signed [8:0] s);
    logic [6:0] r;
    if (s < $signed({2'b00, taeds_pkg::SpeedMin})) begin
      r = taeds_pkg::SpeedMin;
    end else if (s > $signed({2'b00, taeds_pkg::SpeedMax})) begin
      r = taeds_pkg::SpeedMax;
    end else begin
      r = s[6:0];
    end
    return r;
  endfunction

  // Adds to a 16-bit timer and sticks at its top value.
  function automatic logic [15:0] add_sat16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Tilt compensation. The larger of roll and pitch (pitch on a tie) picks
  // the correction: roll speeds up one side by the gain and slows the other
  // by half the gain, pitch shifts both sides by half the gain. The two side
  // speeds are clamped separately and then averaged.
  logic [11:0]        roll_mag;
  logic [11:0]        pitch_mag;
  logic signed [12:0] roll_wide;
  logic signed [12:0] pitch_wide;
  logic signed [12:0] thr_pos;
  logic signed [12:0] thr_neg;
  logic signed [7:0]  gain_s;
  logic signed [7:0]  half_s;
  logic signed [7:0]  left_corr;
  logic signed [7:0]  right_corr;
  logic signed [8:0]  base_s;
  logic [6:0]         left_speed;
  logic [6:0]         right_speed;
  logic [7:0]         pair_sum;
  logic [6:0]         comp_speed;

  always_comb begin
    roll_wide  = {in_tick.roll_tenths[11], in_tick.roll_tenths};
    pitch_wide = {in_tick.pitch_tenths[11], in_tick.pitch_tenths};
    roll_mag   = in_tick.roll_tenths[11] ? 12'(-in_tick.roll_tenths)
                                         : 12'(in_tick.roll_tenths);
    pitch_mag  = in_tick.pitch_tenths[11] ? 12'(-in_tick.pitch_tenths)
                                          : 12'(in_tick.pitch_tenths);
    thr_pos    = $signed({3'b000, tilt_threshold});
    thr_neg    = -thr_pos;
    gain_s     = $signed({2'b00, tilt_gain});
    half_s     = $signed({3'b000, tilt_gain[5:1]});
    left_corr  = '0;
    right_corr = '0;
    if (roll_mag > pitch_mag) begin
      if (roll_wide > thr_pos) begin
        right_corr = gain_s;
        left_corr  = -half_s;
      end else if (roll_wide < thr_neg) begin
        left_corr  = gain_s;
        right_corr = -half_s;
      end
    end else begin
      if (pitch_wide > thr_pos) begin
        left_corr  = half_s;
        right_corr = half_s;
      end else if (pitch_wide < thr_neg) begin
        left_corr  = -half_s;
        right_corr = -half_s;
      end
    end
    base_s      = $signed({2'b00, user_speed});
    left_speed  = clamp_speed(base_s + 9'(left_corr));
    right_speed = clamp_speed(base_s + 9'(right_corr));
    pair_sum    = {1'b0, left_speed} + {1'b0, right_speed};
    if (left_corr != 8'sd0 || right_corr != 8'sd0) begin
      comp_speed = pair_sum[7:1];
    end else begin
      comp_speed = clamp_speed(base_s);
    end
  end

  // Turn timer, stability response, buzzer and edge detection for one tick.
  logic [15:0] left_miss_sum;
  logic [15:0] right_miss_sum;
  logic        left_echo;
  logic        right_echo;
  logic        left_edge;
  logic        right_edge;
  logic        brake;
  logic        speed_valid;
  logic [6:0]  drive_speed;
  taeds_pkg::buzz_t buzz;

  always_comb begin
    turn_active_next   = turn_active;
    turn_elapsed_next  = turn_elapsed;
    left_miss_ms_next  = left_miss_ms;
    right_miss_ms_next = right_miss_ms;
    last_move_next     = last_move;
    brake              = 1'b0;
    speed_valid        = 1'b0;
    drive_speed        = '0;
    buzz               = taeds_pkg::BUZZ_SILENT;

    if (turn_active) begin
      turn_elapsed_next = add_sat16(turn_elapsed, {8'd0, in_tick.elapsed_ms});
      if (turn_elapsed_next >= turn_time_ms) begin
        last_move_next   = taeds_pkg::MOVE_FORWARD;
        turn_active_next = 1'b0;
      end
    end

    if (in_tick.tilt_online) begin
      case (in_tick.stability)
        taeds_pkg::STAB_DANGER: begin
          brake          = 1'b1;
          last_move_next = taeds_pkg::MOVE_STOP;
          buzz           = taeds_pkg::BUZZ_DANGER;
        end
        taeds_pkg::STAB_WARNING: begin
          speed_valid = 1'b1;
          drive_speed = comp_speed;
          buzz        = taeds_pkg::BUZZ_WARNING;
        end
        default: begin
        end
      endcase
    end
    if (in_tick.bin_full && buzz != taeds_pkg::BUZZ_DANGER) begin
      buzz = taeds_pkg::BUZZ_WARNING;
    end

    // A distance of zero or beyond the ground limit counts as a missing echo.
    left_echo      = (in_tick.left_dist != 10'd0) && (in_tick.left_dist <= no_object_cm);
    right_echo     = (in_tick.right_dist != 10'd0) && (in_tick.right_dist <= no_object_cm);
    left_miss_sum  = left_echo ? 16'd0 : add_sat16(left_miss_ms, taeds_pkg::MissStep);
    right_miss_sum = right_echo ? 16'd0 : add_sat16(right_miss_ms, taeds_pkg::MissStep);
    left_edge      = left_miss_sum >= edge_confirm_ms;
    right_edge     = right_miss_sum >= edge_confirm_ms;

    if (!turn_active_next) begin
      left_miss_ms_next  = left_miss_sum;
      right_miss_ms_next = right_miss_sum;
      if (left_edge && right_edge) begin
        last_move_next     = taeds_pkg::MOVE_STOP;
        left_miss_ms_next  = '0;
        right_miss_ms_next = '0;
      end else if (left_edge || right_edge) begin
        last_move_next     = taeds_pkg::MOVE_TURN;
        turn_active_next   = 1'b1;
        turn_elapsed_next  = '0;
        left_miss_ms_next  = '0;
        right_miss_ms_next = '0;
      end
    end

    result_next.move_cmd    = last_move_next;
    result_next.brake       = brake;
    result_next.speed_valid = speed_valid;
    result_next.drive_speed = drive_speed;
    result_next.alarm_level = buzz;
    result_next.turning     = turn_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      turn_active   <= 1'b0;
      turn_elapsed  <= '0;
      left_miss_ms  <= '0;
      right_miss_ms <= '0;
      last_move     <= taeds_pkg::MOVE_NONE;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid     <= 1'b1;
        turn_active   <= turn_active_next;
        turn_elapsed  <= turn_elapsed_next;
        left_miss_ms  <= left_miss_ms_next;
        right_miss_ms <= right_miss_ms_next;
        last_move     <= last_move_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_tick <= req.data;
    end
    if (advance) begin
      out_result <= result_next;
    end
  end

  // A turn starts by clearing both no-echo counters, and they stay idle
  // until it ends.
  `TAEDS_ASSERT_SAME(a_turn_clears_miss, turn_active, left_miss_ms == 16'd0 && right_miss_ms == 16'd0)
  // A braking result always carries the danger alarm and no new speed.
  `TAEDS_ASSERT_SAME(a_brake_alarm, out_valid && out_result.brake, out_result.alarm_level == taeds_pkg::BUZZ_DANGER && !out_result.speed_valid)
  // An issued speed lies in the drive range.
  `TAEDS_ASSERT_SAME(a_speed_range, out_valid && out_result.speed_valid, out_result.drive_speed >= taeds_pkg::SpeedMin && out_result.drive_speed <= taeds_pkg::SpeedMax)
  // The reported turn flag matches the state left behind by that request.
  `TAEDS_ASSERT_NEXT(a_turn_flag, advance, out_result.turning == turn_active)

endmodule
